@@ rtl/core/bpv_pkg.sv @@
// ----------------------------------------------------------------------------
// bpv_pkg
// Widths, limits and shared types for the block pixel variance engine.
// ----------------------------------------------------------------------------
package bpv_pkg;

   localparam int PIX_W      = 8;
   localparam int PIX_MAX    = (1 << PIX_W) - 1;
   localparam int MAX_PIXELS = 4096;

   // accumulator widths follow from the largest block
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = $clog2(longint'(PIX_MAX) * MAX_PIXELS + 1);
   localparam int SQ_W  = $clog2(longint'(PIX_MAX) * PIX_MAX * MAX_PIXELS + 1);

   // shared multiplier operands: A is the wide side, B the narrow side
   localparam int MUL_A_W = SQ_W;
   localparam int MUL_B_W = SUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int NUM_W  = CNT_W + SQ_W;
   localparam int DEN_W  = 2 * SUM_W;
   localparam int NSQ_W  = 2 * CNT_W;
   localparam int FRAC_W = 8;
   localparam int DIVD_W = NUM_W + FRAC_W;
   localparam int VAR_W  = 22;
   localparam int QCNT_W = $clog2(VAR_W);

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [SQ_W-1:0]   square_type;
   typedef logic [VAR_W-1:0]  variance_type;

   typedef struct packed {
      count_type  count;
      sum_type    sum;
      square_type square_sum;
      logic       overflowed;
   } accum_type;

endpackage

@@ rtl/core/bpv_accum.sv @@
// ----------------------------------------------------------------------------
// bpv_accum
// Pixel count, sum and sum of squares for the block in progress.
// ----------------------------------------------------------------------------
module bpv_accum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           pixel,
   input  logic                 clear,
   output bpv_pkg::accum_type   acc
);
   import bpv_pkg::*;

   count_type  count_ff, count_in;
   sum_type    sum_ff, sum_in;
   square_type sq_ff, sq_in;
   logic       ovf_ff, ovf_in;
   logic [2*PIX_W-1:0] pix_sq;

   assign pix_sq = pixel * pixel;

   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      sq_in    = sq_ff;
      ovf_in   = ovf_ff;
      if (clear) begin
         count_in = '0;
         sum_in   = '0;
         sq_in    = '0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         // drop pixels past the block limit and remember it
         if (ovf_ff || (count_ff >= CNT_W'(MAX_PIXELS))) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(pixel);
            sq_in    = sq_ff + SQ_W'(pix_sq);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sq_ff    <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sq_ff    <= sq_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign acc.count      = count_ff;
   assign acc.sum        = sum_ff;
   assign acc.square_sum = sq_ff;
   assign acc.overflowed = ovf_ff;

endmodule

@@ rtl/core/bpv_divider.sv @@
// ----------------------------------------------------------------------------
// bpv_divider
// Restoring divider, one quotient bit per cycle, VAR_W bits of quotient.
// ----------------------------------------------------------------------------
module bpv_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bpv_pkg::DIVD_W-1:0]   dividend,
   input  logic [bpv_pkg::NSQ_W-1:0]    divisor,
   output logic                         done,
   output logic [bpv_pkg::VAR_W-1:0]    quotient
);
   import bpv_pkg::*;

   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] dsh_ff, dsh_in;
   logic [VAR_W-1:0]  q_ff, q_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend;
         // align the divisor with the top quotient bit
         dsh_in = DIVD_W'({divisor, {(VAR_W-1){1'b0}}});
         q_in   = '0;
         cnt_in = QCNT_W'(VAR_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in   = {q_ff[VAR_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - QCNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

@@ rtl/core/block_pixel_variance.sv @@
// ----------------------------------------------------------------------------
// block_pixel_variance
// Population variance of a streamed pixel block, 8 fraction bits, truncated.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_pixel, req_last_pixel               start & !busy
//  response  rsp_variance_q8, rsp_too_many           rsp_strobe, one cycle
//
//  A pixel without the last mark leaves busy low.
//  The last pixel raises busy for three multiplier passes, one compare and the
//  bit-serial divider, then the result is loaded.
//  A zero-variance block drops busy after the compare, an over-limit one after MUL_A.
//  The result beat shows in the cycle busy falls; the receiver cannot stall.
//  Reset clears all accumulators and the sequencer.
// ----------------------------------------------------------------------------
module block_pixel_variance (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [7:0]                   req_pixel,
   input  logic                         req_last_pixel,
   output logic                         rsp_strobe,
   output logic [21:0]                  rsp_variance_q8,
   output logic                         rsp_too_many
);
   import bpv_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL_A = 3'd1;
   localparam logic [2:0] ST_MUL_B = 3'd2;
   localparam logic [2:0] ST_MUL_C = 3'd3;
   localparam logic [2:0] ST_CMP   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;

   logic [2:0]         state_ff, state_in;
   accum_type          acc;
   logic               accept;
   logic               finish;
   logic               fin_ovf;
   variance_type       fin_var;
   logic [MUL_A_W-1:0] op_a;
   logic [MUL_B_W-1:0] op_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   diff;
   logic               div_start;
   logic               div_done;
   variance_type       div_q;
   logic               strobe_ff;
   variance_type       var_ff, var_in;
   logic               tm_ff, tm_in;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   bpv_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .pixel  (req_pixel),
      .clear  (finish),
      .acc    (acc)
   );

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_MUL_A: begin
            op_a = acc.square_sum;
            op_b = MUL_B_W'(acc.count);
         end
         ST_MUL_B: begin
            op_a = MUL_A_W'(acc.sum);
            op_b = acc.sum;
         end
         ST_MUL_C: begin
            op_a = MUL_A_W'(acc.count);
            op_b = MUL_B_W'(acc.count);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      num_ff  <= num_in;
      den_ff  <= den_in;
      var_ff  <= var_in;
      tm_ff   <= tm_in;
   end

   assign diff = num_ff - NUM_W'(den_ff);

   bpv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({diff, {FRAC_W{1'b0}}}),
      .divisor  (prod_ff[NSQ_W-1:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      div_start = 1'b0;
      finish    = 1'b0;
      fin_ovf   = 1'b0;
      fin_var   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_pixel) begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            if (acc.overflowed) begin
               finish   = 1'b1;
               fin_ovf  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            num_in   = prod_ff[NUM_W-1:0];
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            den_in   = prod_ff[DEN_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // a flat block gives zero without the divider
            if (num_ff <= NUM_W'(den_ff)) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               finish   = 1'b1;
               fin_var  = div_q;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign var_in = finish ? fin_var : var_ff;
   assign tm_in  = finish ? fin_ovf : tm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= finish;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_variance_q8 = var_ff;
   assign rsp_too_many    = tm_ff;

endmodule
